FILE: rtl/tirc_pkg.sv
`default_nettype none
package tirc_pkg;

	localparam int unsigned TimeW = 64;
	localparam int unsigned DataW = 64;
	localparam int unsigned CountW = 8;
	localparam int unsigned IdW = 10;
	localparam int unsigned SizeW = 4;

	localparam logic [SizeW-1:0] SizeB1 = 4'd1;
	localparam logic [SizeW-1:0] SizeB2 = 4'd2;
	localparam logic [SizeW-1:0] SizeB4 = 4'd4;
	localparam logic [SizeW-1:0] SizeB8 = 4'd8;

	// classified sample handed from front to back
	typedef struct packed {
		logic [IdW-1:0]   id;
		logic [TimeW-1:0] t;
		logic             opens;
		logic [DataW-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [IdW-1:0]    id;
		logic [TimeW-1:0]  rbegin;
		logic [TimeW-1:0]  rend;
		logic [DataW-1:0]  value;
		logic [CountW-1:0] count;
	} run_t;

	function automatic logic [DataW-1:0] mask_value(input logic [SizeW-1:0] size,
		input logic [DataW-1:0] data);
		logic [DataW-1:0] v;
		begin
			unique case (size)
				SizeB1:  v = {56'd0, data[7:0]};
				SizeB2:  v = {48'd0, data[15:0]};
				SizeB4:  v = {32'd0, data[31:0]};
				default: v = data;
			endcase
			return v;
		end
	endfunction

endpackage
`default_nettype wire

FILE: rtl/tirc_front.sv
`default_nettype none
module tirc_front #(
	parameter int unsigned TRACE_IDS = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic [tirc_pkg::IdW-1:0]   sig_id,
	input  wire logic [tirc_pkg::TimeW-1:0] sample_time,
	input  wire logic [tirc_pkg::SizeW-1:0] sample_size,
	input  wire logic [tirc_pkg::DataW-1:0] sample_data,
	input  wire logic                      is_varlen,
	output logic                           cmd_valid,
	output tirc_pkg::cmd_t                 cmd,
	input  wire logic                      cmd_take
);
	import tirc_pkg::*;

	localparam int unsigned Depth = 2;

	cmd_t       fifo_q [Depth];
	logic [0:0] wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       keep, acc;
	cmd_t       c;

	always_comb begin
		keep = !is_varlen && ({22'd0, sig_id} < 32'(TRACE_IDS));
		c.id = sig_id;
		c.t = sample_time;
		c.opens = (sample_size == SizeB1) || (sample_size == SizeB2) ||
			(sample_size == SizeB4) || (sample_size == SizeB8);
		c.value = mask_value(sample_size, sample_data);
	end

	assign full = (cnt_q == 2'(Depth));
	assign acc = push && !full && keep;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (acc) fifo_q[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (acc) wr_q <= wr_q + 1'b1;
			if (cmd_take) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + 2'(acc) - 2'(cmd_take);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/tirc_div.sv
`default_nettype none
module tirc_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [tirc_pkg::TimeW-1:0]  dividend,
	input  wire logic [tirc_pkg::CountW-1:0] divisor,
	output logic                            done,
	output logic [tirc_pkg::TimeW-1:0]      quotient
);
	import tirc_pkg::*;

	// eight quotient bits a cycle, radix-2 restoring steps chained narrowly
	localparam int unsigned Steps = 8;
	localparam int unsigned Rounds = TimeW / Steps;

	logic [TimeW-1:0]  q_q;
	logic [CountW:0]   rem_q;
	logic [CountW-1:0] d_q;
	logic [3:0]        round_q;
	logic              busy_q;
	logic [CountW:0]   r;
	logic [TimeW-1:0]  q;

	always_comb begin
		r = rem_q;
		q = q_q;
		for (int i = 0; i < Steps; i++) begin
			r = {r[CountW-1:0], q[TimeW-1]};
			q = {q[TimeW-2:0], 1'b0};
			if (r >= {1'b0, d_q}) begin
				r = r - {1'b0, d_q};
				q[0] = 1'b1;
			end
		end
	end

	assign quotient = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			round_q <= '0;
			q_q <= '0;
			rem_q <= '0;
			d_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				q_q <= dividend;
				rem_q <= '0;
				d_q <= divisor;
				round_q <= '0;
			end else if (busy_q) begin
				q_q <= q;
				rem_q <= r;
				round_q <= round_q + 4'd1;
				if (round_q == 4'(Rounds - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/tirc_back.sv
`default_nettype none
module tirc_back #(
	parameter int unsigned TRACE_IDS = 1024,
	parameter int unsigned MAX_REPEAT = 255
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire tirc_pkg::cmd_t cmd,
	output logic               cmd_take,
	output logic               empty,
	input  wire logic          pop,
	output tirc_pkg::run_t     res
);
	import tirc_pkg::*;

	localparam int unsigned AW = (TRACE_IDS > 1) ? $clog2(TRACE_IDS) : 1;

	typedef enum logic [2:0] {S_CLR, S_IDLE, S_READ, S_EVAL, S_DIV, S_DEC, S_OUT} state_t;

	logic [TimeW-1:0]  ob_mem [TRACE_IDS];
	logic [DataW-1:0]  ov_mem [TRACE_IDS];
	logic [TimeW-1:0]  rs_mem [TRACE_IDS];
	logic [TimeW-1:0]  re_mem [TRACE_IDS];
	logic [DataW-1:0]  rd_mem [TRACE_IDS];
	logic [CountW-1:0] rc_mem [TRACE_IDS];
	// {open valid, run valid} per id
	logic [1:0]        vld_mem [TRACE_IDS];

	state_t            state_q;
	logic [AW-1:0]     clr_q;
	cmd_t              c_q;
	logic [AW-1:0]     a;
	logic [TimeW-1:0]  ob_q, rs_q, re_q;
	logic [DataW-1:0]  ovl_q, rd_q;
	logic [CountW-1:0] rc_q;
	logic              ovv_q, rvv_q, match_q;
	logic              wr_run, wr_open;
	run_t              new_run;
	logic              div_start, div_done;
	logic [TimeW-1:0]  div_q;
	logic              out_q;

	assign a = AW'(c_q.id);
	assign cmd_take = (state_q == S_IDLE) && cmd_valid;
	assign empty = !out_q;

	tirc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(re_q - rs_q), .divisor(rc_q),
		.done(div_done), .quotient(div_q)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			ob_q <= ob_mem[a];
			ovl_q <= ov_mem[a];
			rs_q <= rs_mem[a];
			re_q <= re_mem[a];
			rd_q <= rd_mem[a];
			rc_q <= rc_mem[a];
			{ovv_q, rvv_q} <= vld_mem[a];
		end
		if (state_q == S_CLR)
			vld_mem[clr_q] <= 2'b00;
		else if (state_q == S_DEC)
			vld_mem[a] <= {ovv_q | c_q.opens, rvv_q | ovv_q};
		if (wr_open) begin
			ob_mem[a] <= c_q.t;
			ov_mem[a] <= c_q.value;
		end
		if (wr_run) begin
			rs_mem[a] <= new_run.rbegin;
			re_mem[a] <= new_run.rend;
			rd_mem[a] <= new_run.value;
			rc_mem[a] <= new_run.count;
		end
	end

	// write-back step, shared by all decisions
	logic merge_now;
	always_comb begin
		wr_run = 1'b0;
		wr_open = 1'b0;
		div_start = 1'b0;
		merge_now = 1'b0;
		new_run.id = c_q.id;
		new_run.rbegin = ob_q;
		new_run.rend = c_q.t;
		new_run.value = ovl_q;
		new_run.count = 8'd1;
		if (state_q == S_EVAL) div_start = ovv_q && rvv_q;
		if (state_q == S_DEC) begin
			merge_now = match_q && (div_q == c_q.t - ob_q);
			wr_open = c_q.opens;
			wr_run = ovv_q;
			if (merge_now) begin
				new_run.rbegin = rs_q;
				new_run.count = rc_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			c_q <= '0;
			res <= '0;
			out_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!out_q || pop)) out_q <= 1'b1;
			else if (pop && out_q) out_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(TRACE_IDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_valid) begin
						c_q <= cmd;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					match_q <= (re_q == ob_q) && (rd_q == ovl_q) && (rc_q != 8'd0) &&
						({24'd0, rc_q} < 32'(MAX_REPEAT));
					state_q <= (ovv_q && rvv_q) ? S_DIV : S_DEC;
					if (!(ovv_q && rvv_q)) match_q <= 1'b0;
				end
				S_DIV: begin
					if (div_done) state_q <= S_DEC;
				end
				S_DEC: begin
					if (ovv_q && rvv_q && !merge_now) state_q <= S_OUT;
					else state_q <= S_IDLE;
				end
				S_OUT: begin
					// hold until the result register is free
					if (!out_q || pop) begin
						res <= '{id: c_q.id, rbegin: rs_q, rend: re_q, value: rd_q,
							count: rc_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/trace_interval_rle_coalescer.sv
// Trace interval run-length coalescer.
// Input channel: push/full carrying sig_id, sample_time, sample_size, sample_data
// and is_varlen. Result channel: empty/pop carrying one emitted run (id, begin,
// end, value, count); the run is on the ports while empty is low.
// Variable-length samples and ids of TRACE_IDS or more are taken and dropped.
// A two-entry queue holds classified samples; the back end then reads the
// per-id entries, runs an 8-round divider (8 quotient bits a round) when
// the id has both an open interval and a pending run, and writes back,
// emitting a run when one ends. It takes a new sample only once it is
// back in idle, so each sample is finished before the next is taken.
// After reset the back end clears the per-id valid bits, one entry a cycle;
// samples wait in the input queue meanwhile.
// A stalled receiver holds one result; the back end waits with the next
// and the input queue fills, after which full stays high.
`default_nettype none
module trace_interval_rle_coalescer #(
	parameter int unsigned TRACE_IDS = 1024,
	parameter int unsigned MAX_REPEAT = 255
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output logic                            full,
	input  wire logic [tirc_pkg::IdW-1:0]    sig_id,
	input  wire logic [tirc_pkg::TimeW-1:0]  sample_time,
	input  wire logic [tirc_pkg::SizeW-1:0]  sample_size,
	input  wire logic [tirc_pkg::DataW-1:0]  sample_data,
	input  wire logic                       is_varlen,
	output logic                            empty,
	input  wire logic                       pop,
	output logic [tirc_pkg::IdW-1:0]         out_trace_id,
	output logic [tirc_pkg::TimeW-1:0]       run_begin,
	output logic [tirc_pkg::TimeW-1:0]       run_end,
	output logic [tirc_pkg::DataW-1:0]       run_value,
	output logic [tirc_pkg::CountW-1:0]      run_count
);
	import tirc_pkg::*;

	logic cmd_valid, cmd_take;
	cmd_t cmd;
	run_t res;

	tirc_front #(.TRACE_IDS(TRACE_IDS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.sig_id(sig_id), .sample_time(sample_time), .sample_size(sample_size),
		.sample_data(sample_data), .is_varlen(is_varlen),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
	);

	tirc_back #(.TRACE_IDS(TRACE_IDS), .MAX_REPEAT(MAX_REPEAT)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take), .empty(empty), .pop(pop), .res(res)
	);

	assign out_trace_id = res.id;
	assign run_begin = res.rbegin;
	assign run_end = res.rend;
	assign run_value = res.value;
	assign run_count = res.count;
endmodule
`default_nettype wire

FILE: rtl/tirc_checker.sv
`default_nettype none
module tirc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       full,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [7:0] run_count,
	input wire logic [63:0] run_begin
);
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result shown in reset");
	a_reset_full: assert property (@(posedge clk) !arst_n |-> !full)
		else $error("full in reset");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> run_count != 8'd0)
		else $error("zero run count");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(run_begin)))
		else $error("result changed while stalled");
endmodule

bind trace_interval_rle_coalescer tirc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .full(full), .empty(empty), .pop(pop),
	.run_count(run_count), .run_begin(run_begin)
);
`default_nettype wire
